>>> hw/rtl/signed_fixed_width_decimal_ascii_macros.svh
// Assertion macros shared by the converter RTL.
// Each macro expects clk and rst_n in scope.
`ifndef SIGNED_FIXED_WIDTH_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_FIXED_WIDTH_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SFDA_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sfda assertion failed");

// Next-cycle implication, checked outside reset
`define SFDA_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sfda assertion failed");

`endif

>>> hw/rtl/sfda_pkg.sv
`timescale 1ns / 1ps

package sfda_pkg;

    // Fixed field widths
    localparam int COUNT_WIDTH = 4;
    localparam int CHAR_WIDTH  = 7;

    // ASCII codes
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'd45;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    // Control of the shift-add-3 unit
    typedef struct packed {
        logic clear;
        logic shift;
        logic bit_in;
    } dab_ctrl_t;

endpackage

>>> hw/rtl/sfda_intf.sv
`timescale 1ns / 1ps

interface sfda_item_if
    import sfda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]        digit_count;

    modport source (output valid, output value, output digit_count, input ready);
    modport sink   (input valid, input value, input digit_count, output ready);
endinterface

interface sfda_char_if
    import sfda_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> hw/rtl/signed_fixed_width_decimal_ascii.sv
// Flow: accept, then shift-add-3 conversion of all VALUE_WIDTH bits, then one
// character per cycle (minus sign if negative, then the digits) while the sink is ready.
// Items: a new item is accepted only in idle, once the previous one is through;
// the bit-serial conversion loop runs through the shared BCD unit.
// Reset: rst_n clears the sequencer to idle, no transaction in flight.
`timescale 1ns / 1ps

`include "signed_fixed_width_decimal_ascii_macros.svh"

module signed_fixed_width_decimal_ascii
    import sfda_pkg::*;
#(
    parameter int MAX_DIGITS  = 10,
    parameter int VALUE_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    sfda_item_if.sink       item,
    sfda_char_if.source     chars
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int SW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;
    localparam int BW = $clog2(VALUE_WIDTH);

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [SW-1:0]          cnt_wide;
    logic [CW-1:0]          cnt_sat;
    logic [CW-1:0]          cnt_dec;
    logic [IW-1:0]          digit_idx;
    logic [3:0]             digits [MAX_DIGITS];
    dab_ctrl_t              dab_ctrl;
    logic                   char_legal;

    // Decode the incoming transaction
    assign raw      = VALUE_WIDTH'(item.value);
    assign cnt_wide = SW'(item.digit_count);
    assign cnt_sat  = (cnt_wide > SW'(MAX_DIGITS)) ? CW'(MAX_DIGITS) : CW'(cnt_wide);
    assign cnt_dec  = cnt_reg - CW'(1);
    assign digit_idx = cnt_dec[IW-1:0];

    sfda_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk    (clk),
        .ctrl   (dab_ctrl),
        .digits (digits)
    );

    // Sequence conversion and character emission
    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        dab_ctrl.clear  = 1'b0;
        dab_ctrl.shift  = 1'b0;
        dab_ctrl.bit_in = mag_reg[VALUE_WIDTH-1];
        item.ready      = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = ASCII_MINUS;
        chars.last      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    neg_next       = raw[VALUE_WIDTH-1];
                    mag_next       = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
                    cnt_next       = cnt_sat;
                    bit_cnt_next   = BW'(VALUE_WIDTH - 1);
                    dab_ctrl.clear = 1'b1;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                dab_ctrl.shift = 1'b1;
                mag_next       = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next   = bit_cnt_reg - BW'(1);
                if (bit_cnt_reg == '0)
                begin
                    if (neg_reg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_SIGN:
            begin
                chars.valid     = 1'b1;
                chars.char_code = ASCII_MINUS;
                chars.last      = (cnt_reg == '0);
                if (chars.ready)
                begin
                    state_next = (cnt_reg == '0) ? ST_IDLE : ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                chars.valid     = 1'b1;
                chars.char_code = ASCII_ZERO + {3'b000, digits[digit_idx]};
                chars.last      = (cnt_reg == CW'(1));
                if (chars.ready)
                begin
                    cnt_next = cnt_dec;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the working value and counters
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        cnt_reg     <= cnt_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    // Flag an outgoing code that is a minus sign or a decimal digit
    assign char_legal = (chars.char_code == ASCII_MINUS) ||
                        ((chars.char_code >= ASCII_ZERO) &&
                         (chars.char_code <= ASCII_ZERO + 7'd9));

    `SFDA_ASSERT_NOW(a_ready_excl_valid, item.ready, !chars.valid)
    `SFDA_ASSERT_NEXT(a_accept_busy, item.valid && item.ready, !item.ready)
    `SFDA_ASSERT_NEXT(a_last_frees, chars.valid && chars.ready && chars.last, item.ready)
    `SFDA_ASSERT_NOW(a_char_legal, chars.valid, char_legal)

endmodule

>>> hw/rtl/sfda_dabble.sv
`timescale 1ns / 1ps

module sfda_dabble
    import sfda_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic       clk,
    input  dab_ctrl_t  ctrl,
    output logic [3:0] digits [MAX_DIGITS]
);

    logic [3:0] bcd_reg  [MAX_DIGITS];
    logic [3:0] bcd_next [MAX_DIGITS];
    logic [3:0] adj      [MAX_DIGITS];

    // Add three to every digit of five or more, then shift one bit in
    always_comb
    begin
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            adj[j] = (bcd_reg[j] >= 4'd5) ? bcd_reg[j] + 4'd3 : bcd_reg[j];
        end
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (ctrl.clear)
            begin
                bcd_next[j] = 4'd0;
            end
            else if (ctrl.shift)
            begin
                if (j == 0)
                begin
                    bcd_next[j] = {adj[j][2:0], ctrl.bit_in};
                end
                else
                begin
                    bcd_next[j] = {adj[j][2:0], adj[j-1][3]};
                end
            end
            else
            begin
                bcd_next[j] = bcd_reg[j];
            end
        end
    end

    // Hold the decimal digits; carry out of the top digit is dropped
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            bcd_reg[j] <= bcd_next[j];
        end
    end

    assign digits = bcd_reg;

endmodule
